// File: design/knn_pkg.sv
// Shared constants and types of the nearest-neighbor digit classifier.
package knn_pkg;

  // Default geometry: a 28 x 28 image, eight list slots, ten digit classes
  localparam int PIXELS_PER_IMAGE_DEF = 28 * 28;
  localparam int MAX_K_DEF            = 8;
  localparam int NUM_CLASSES_DEF      = 10;

  // Field widths
  localparam int PIX_W   = 8;
  localparam int LABEL_W = 4;
  localparam int K_W     = 4;
  localparam int VOTE_W  = 4;
  localparam int SQ_W    = 2 * PIX_W;

  // Squared distance, saturating at all ones
  localparam int                DIST_W   = 26;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Reset value of the neighbor count register
  localparam logic [K_W-1:0] K_RESET = K_W'(5);

  // Depth of the image-end queue between the front and the back
  localparam int QUEUE_DEPTH = 4;

  // Wide enough for any vote count or k up to 32 slots
  localparam int CNT_EXT_W = 6;

  typedef enum logic {
    OP_QUERY = 1'b0,
    OP_TRAIN = 1'b1
  } opcode_t;

  // One finished training image on its way to the neighbor list
  typedef struct packed {
    logic [DIST_W-1:0]  sq_dist;
    logic [LABEL_W-1:0] label;
    logic               last_image;
  } ev_t;

endpackage

// File: design/knn_digit_classifier.sv
// Top level of the k-nearest-neighbor digit classifier.
// Throughput: one pixel item per cycle while in_stall is low, query and training pixels alike.
// Path of a result from the item that ends the training set: two front stages, the image-end queue,
// two vote stages and the result register.
// The front stalls only while an image end waits for a full queue; the queue holds four.
// Synchronous active-low reset empties the list and pipelines, sets k to 5; query store is not cleared.
module knn_digit_classifier #(
  parameter int PIXELS_PER_IMAGE = knn_pkg::PIXELS_PER_IMAGE_DEF,
  parameter int MAX_K            = knn_pkg::MAX_K_DEF,
  parameter int NUM_CLASSES      = knn_pkg::NUM_CLASSES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [knn_pkg::PIX_W-1:0]   in_pixel,
  input  logic [knn_pkg::LABEL_W-1:0] in_label,
  input  logic                        in_last_pixel,
  input  logic                        in_last_image,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [knn_pkg::LABEL_W-1:0] out_predicted_label,
  output logic [knn_pkg::VOTE_W-1:0]  out_vote_count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [knn_pkg::K_W-1:0]     cfg_k_neighbors
);
  import knn_pkg::*;

  logic [K_W-1:0] k_r;
  logic           push, q_full, pop, q_nonempty;
  ev_t            push_ev, head_ev;

  // Neighbor count register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= K_RESET;
    end else if (cfg_valid && cfg_ready) begin
      k_r <= cfg_k_neighbors;
    end
  end

  knn_front #(
    .PIXELS_PER_IMAGE(PIXELS_PER_IMAGE)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_pixel     (in_pixel),
    .in_label     (in_label),
    .in_last_pixel(in_last_pixel),
    .in_last_image(in_last_image),
    .push         (push),
    .push_ev      (push_ev),
    .q_full       (q_full)
  );

  knn_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_ev (push_ev),
    .full    (q_full),
    .pop     (pop),
    .head_ev (head_ev),
    .nonempty(q_nonempty)
  );

  knn_back #(
    .MAX_K      (MAX_K),
    .NUM_CLASSES(NUM_CLASSES)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .k_neighbors        (k_r),
    .ev_valid           (q_nonempty),
    .ev                 (head_ev),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_predicted_label(out_predicted_label),
    .out_vote_count     (out_vote_count)
  );

endmodule

// File: design/knn_front.sv
// Front part: query store, squared pixel difference and per-image distance accumulation.
module knn_front #(
  parameter int PIXELS_PER_IMAGE = knn_pkg::PIXELS_PER_IMAGE_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_opcode,
  input  logic [knn_pkg::PIX_W-1:0]  in_pixel,
  input  logic [knn_pkg::LABEL_W-1:0] in_label,
  input  logic                       in_last_pixel,
  input  logic                       in_last_image,
  output logic                       push,
  output knn_pkg::ev_t               push_ev,
  input  logic                       q_full
);
  import knn_pkg::*;

  localparam int IDX_W = (PIXELS_PER_IMAGE > 1) ? $clog2(PIXELS_PER_IMAGE) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PIXELS_PER_IMAGE - 1);

  logic [PIX_W-1:0] qmem [PIXELS_PER_IMAGE];

  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               s1_v_r, s2_v_r;
  opcode_t            s1_op_r, s2_op_r;
  logic [PIX_W-1:0]   s1_pix_r, q_rd_r;
  logic [LABEL_W-1:0] s1_label_r, s2_label_r;
  logic               s1_lp_r, s1_li_r, s2_lp_r, s2_li_r;
  logic [SQ_W-1:0]    s2_sq_r;
  logic [DIST_W-1:0]  acc_r, acc_nxt;

  logic              adv, accept, s2_end;
  logic [PIX_W-1:0]  diff;
  logic [SQ_W-1:0]   sq;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] acc_sat;

  // Hold the whole front while an image end waits for queue space
  assign s2_end   = s2_v_r && (s2_op_r == OP_TRAIN) && s2_lp_r;
  assign adv      = !(s2_end && q_full);
  assign in_stall = !adv;
  assign accept   = in_valid && adv;

  // Advance pixel position, wrap at the image size or on last pixel
  always_comb begin
    idx_nxt = idx_r;
    if (accept) begin
      if (in_last_pixel || (idx_r == IDX_LAST)) begin
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
    end
  end

  // Query store: write query pixels, read the matching query pixel
  always_ff @(posedge clk) begin
    if (accept && (opcode_t'(in_opcode) == OP_QUERY)) begin
      qmem[idx_r] <= in_pixel;
    end
    if (adv) begin
      q_rd_r <= qmem[idx_r];
    end
  end

  // Absolute difference and square
  always_comb begin
    diff = (s1_pix_r > q_rd_r) ? (s1_pix_r - q_rd_r) : (q_rd_r - s1_pix_r);
    sq   = SQ_W'(diff) * SQ_W'(diff);
  end

  // Saturating accumulate
  always_comb begin
    sum     = {1'b0, acc_r} + (DIST_W + 1)'(s2_sq_r);
    acc_sat = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    acc_nxt = acc_r;
    if (adv && s2_v_r && (s2_op_r == OP_TRAIN)) begin
      acc_nxt = s2_lp_r ? '0 : acc_sat;
    end
  end

  assign push               = s2_end && adv;
  assign push_ev.sq_dist    = acc_sat;
  assign push_ev.label      = s2_label_r;
  assign push_ev.last_image = s2_li_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      acc_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      acc_r <= acc_nxt;
      if (adv) begin
        s1_v_r <= accept;
        s2_v_r <= s1_v_r;
      end
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r    <= opcode_t'(in_opcode);
      s1_pix_r   <= in_pixel;
      s1_label_r <= in_label;
      s1_lp_r    <= in_last_pixel;
      s1_li_r    <= in_last_image;
      s2_op_r    <= s1_op_r;
      s2_sq_r    <= sq;
      s2_label_r <= s1_label_r;
      s2_lp_r    <= s1_lp_r;
      s2_li_r    <= s1_li_r;
    end
  end

endmodule

// File: design/knn_queue.sv
// Short queue of finished training images between the front and the back.
module knn_queue #(
  parameter int DEPTH = knn_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  knn_pkg::ev_t push_ev,
  output logic         full,
  input  logic         pop,
  output knn_pkg::ev_t head_ev,
  output logic         nonempty
);
  import knn_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  ev_t              slot_r [DEPTH];
  logic [PTR_W-1:0] wr_r, rd_r;
  logic [CNT_W-1:0] cnt_r;

  assign full     = (cnt_r == CNT_FULL);
  assign nonempty = (cnt_r != '0);
  assign head_ev  = slot_r[rd_r];

  // Store pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_ev;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_LAST) ? '0 : wr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_LAST) ? '0 : rd_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// File: design/knn_back.sv
// Back part: sorted list of the nearest images, majority vote and result register.
module knn_back #(
  parameter int MAX_K       = knn_pkg::MAX_K_DEF,
  parameter int NUM_CLASSES = knn_pkg::NUM_CLASSES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [knn_pkg::K_W-1:0]     k_neighbors,
  input  logic                        ev_valid,
  input  knn_pkg::ev_t                ev,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [knn_pkg::LABEL_W-1:0] out_predicted_label,
  output logic [knn_pkg::VOTE_W-1:0]  out_vote_count
);
  import knn_pkg::*;

  localparam int CNT_W = $clog2(MAX_K + 1);

  // Neighbor list
  logic [DIST_W-1:0]  best_dist_r  [MAX_K];
  logic [LABEL_W-1:0] best_label_r [MAX_K];
  logic [MAX_K-1:0]   best_valid_r;

  // Vote pipeline
  logic               v1_v_r, v2_v_r, out_valid_r;
  logic [LABEL_W-1:0] v1_label_r [MAX_K];
  logic [MAX_K-1:0]   v1_vote_r;
  logic [CNT_W-1:0]   v2_cnt_r [NUM_CLASSES];
  logic [LABEL_W-1:0] out_label_r;
  logic [VOTE_W-1:0]  out_cnt_r;

  logic [MAX_K-1:0]     lt, ins_at, new_valid, vote_mask;
  logic [DIST_W-1:0]    prev_dist  [MAX_K];
  logic [LABEL_W-1:0]   prev_label [MAX_K];
  logic [MAX_K-1:0]     prev_valid;
  logic [DIST_W-1:0]    new_dist   [MAX_K];
  logic [LABEL_W-1:0]   new_label  [MAX_K];
  logic [CNT_EXT_W-1:0] k_ext, k_eff;
  logic                 vadv, pop_last;
  logic [CNT_W-1:0]     cnt [NUM_CLASSES];
  logic [CNT_W-1:0]     best_c;
  logic [LABEL_W-1:0]   best_l;
  logic [CNT_EXT_W-1:0] best_ext;
  logic [VOTE_W-1:0]    best_sat;

  // Take an item unless it needs the vote pipeline and that is held
  assign vadv     = !out_valid_r || !out_stall;
  assign pop      = ev_valid && (!ev.last_image || vadv);
  assign pop_last = pop && ev.last_image;

  // Place of the new entry: the list is a valid prefix in ascending order,
  // so the compare vector is a thermometer and its first set bit is the slot
  always_comb begin
    for (int i = 0; i < MAX_K; i++) begin
      lt[i] = !best_valid_r[i] || (ev.sq_dist < best_dist_r[i]);
    end
    ins_at[0]     = lt[0];
    prev_dist[0]  = '0;
    prev_label[0] = '0;
    prev_valid[0] = 1'b0;
    for (int i = 1; i < MAX_K; i++) begin
      ins_at[i]     = lt[i] && !lt[i-1];
      prev_dist[i]  = best_dist_r[i-1];
      prev_label[i] = best_label_r[i-1];
      prev_valid[i] = best_valid_r[i-1];
    end
    for (int i = 0; i < MAX_K; i++) begin
      if (ins_at[i]) begin
        new_dist[i]  = ev.sq_dist;
        new_label[i] = ev.label;
        new_valid[i] = 1'b1;
      end else if (lt[i]) begin
        new_dist[i]  = prev_dist[i];
        new_label[i] = prev_label[i];
        new_valid[i] = prev_valid[i];
      end else begin
        new_dist[i]  = best_dist_r[i];
        new_label[i] = best_label_r[i];
        new_valid[i] = best_valid_r[i];
      end
    end
  end

  // Clamp k to one .. MAX_K and mark the voting entries
  always_comb begin
    k_ext = CNT_EXT_W'(k_neighbors);
    if (k_ext == '0) begin
      k_eff = CNT_EXT_W'(1);
    end else if (k_ext > CNT_EXT_W'(MAX_K)) begin
      k_eff = CNT_EXT_W'(MAX_K);
    end else begin
      k_eff = k_ext;
    end
    for (int i = 0; i < MAX_K; i++) begin
      vote_mask[i] = new_valid[i] && ({1'b0, new_label[i]} < (LABEL_W + 1)'(NUM_CLASSES))
                     && (CNT_EXT_W'(i) < k_eff);
    end
  end

  // Count votes per class
  always_comb begin
    logic [MAX_K-1:0] match;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      for (int i = 0; i < MAX_K; i++) begin
        match[i] = v1_vote_r[i] && (v1_label_r[i] == LABEL_W'(c));
      end
      cnt[c] = CNT_W'($countones(match));
    end
  end

  // Pick the largest count, the smaller label on a tie
  always_comb begin
    best_c = '0;
    best_l = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (v2_cnt_r[c] > best_c) begin
        best_c = v2_cnt_r[c];
        best_l = LABEL_W'(c);
      end
    end
    best_ext = CNT_EXT_W'(best_c);
    best_sat = (best_ext > CNT_EXT_W'(15)) ? VOTE_W'(15) : best_ext[VOTE_W-1:0];
  end

  // Update the list, clear it once the training set ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= '0;
    end else if (pop) begin
      best_valid_r <= ev.last_image ? '0 : new_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_K; i++) begin
        best_dist_r[i]  <= DIST_MAX;
        best_label_r[i] <= '0;
      end
    end else if (pop && !ev.last_image) begin
      for (int i = 0; i < MAX_K; i++) begin
        best_dist_r[i]  <= new_dist[i];
        best_label_r[i] <= new_label[i];
      end
    end
  end

  // Vote pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_v_r      <= 1'b0;
      v2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (vadv) begin
      v1_v_r      <= pop_last;
      v2_v_r      <= v1_v_r;
      out_valid_r <= v2_v_r;
    end
  end

  // Vote pipeline payload
  always_ff @(posedge clk) begin
    if (vadv) begin
      for (int i = 0; i < MAX_K; i++) begin
        v1_label_r[i] <= new_label[i];
      end
      v1_vote_r <= vote_mask;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        v2_cnt_r[c] <= cnt[c];
      end
      out_label_r <= best_l;
      out_cnt_r   <= best_sat;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_predicted_label = out_label_r;
  assign out_vote_count      = out_cnt_r;

endmodule

// File: tb/sv/knn_vote_checker.sv
// Checker that predicts the classifier's votes and compares them with its results.
module knn_vote_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_opcode,
  input  logic [knn_pkg::PIX_W-1:0]   in_pixel,
  input  logic [knn_pkg::LABEL_W-1:0] in_label,
  input  logic                        in_last_pixel,
  input  logic                        in_last_image,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [knn_pkg::LABEL_W-1:0] out_predicted_label,
  input  logic [knn_pkg::VOTE_W-1:0]  out_vote_count,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [knn_pkg::K_W-1:0]     cfg_k_neighbors,
  output int                          failures,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import knn_pkg::*;

  localparam int IMG_PIXELS = PIXELS_PER_IMAGE_DEF;
  localparam int SLOTS      = MAX_K_DEF;
  localparam int CLASSES    = NUM_CLASSES_DEF;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [VOTE_W-1:0]  votes;
  } verdict_t;

  logic [PIX_W-1:0]   query_img  [IMG_PIXELS];
  int                 pix_pos;
  logic [DIST_W-1:0]  dist_acc;
  logic [DIST_W-1:0]  near_dist  [SLOTS];
  logic [LABEL_W-1:0] near_label [SLOTS];
  bit                 near_used  [SLOTS];
  logic [K_W-1:0]     vote_k;
  verdict_t           expected_votes [$];
  int                 fail_count = 0;
  int                 pend_count = 0;

  assign failures = fail_count;
  assign pending  = pend_count;

  // Empty the neighbor list
  function automatic void clear_ranking();
    for (int i = 0; i < SLOTS; i++) begin
      near_dist[i]  = DIST_MAX;
      near_label[i] = '0;
      near_used[i]  = 1'b0;
    end
  endfunction

  // Insert a finished image ahead of the first slot it strictly beats
  function automatic void rank_image(logic [DIST_W-1:0] img_dist, logic [LABEL_W-1:0] lab);
    int slot;
    slot = SLOTS;
    for (int i = SLOTS - 1; i >= 0; i--)
      if (!near_used[i] || img_dist < near_dist[i]) slot = i;
    if (slot < SLOTS) begin
      for (int j = SLOTS - 1; j > slot; j--) begin
        near_dist[j]  = near_dist[j-1];
        near_label[j] = near_label[j-1];
        near_used[j]  = near_used[j-1];
      end
      near_dist[slot]  = img_dist;
      near_label[slot] = lab;
      near_used[slot]  = 1'b1;
    end
  endfunction

  // Majority label among the first k valid entries, smaller label on ties
  function automatic verdict_t tally_votes();
    int       votes [16];
    int       k;
    int       lead;
    int       lead_n;
    verdict_t v;
    if (vote_k == '0) k = 1;
    else if (int'(vote_k) > SLOTS) k = SLOTS;
    else k = int'(vote_k);
    for (int i = 0; i < 16; i++) votes[i] = 0;
    for (int i = 0; i < k; i++)
      if (near_used[i] && int'(near_label[i]) < CLASSES) votes[near_label[i]]++;
    lead   = 0;
    lead_n = 0;
    for (int i = 0; i < CLASSES; i++) begin
      if (votes[i] > lead_n) begin
        lead_n = votes[i];
        lead   = i;
      end
    end
    if (lead_n > 15) lead_n = 15;
    v.label = LABEL_W'(lead);
    v.votes = VOTE_W'(lead_n);
    return v;
  endfunction

  // Advance the prediction by one accepted pixel item
  function automatic void take_pixel(opcode_t op, logic [PIX_W-1:0] pix,
                                     logic [LABEL_W-1:0] lab, logic lp, logic li);
    int                pos;
    int                diff;
    logic [DIST_W:0]   sum;
    pos = (pix_pos < IMG_PIXELS) ? pix_pos : 0;
    if (op == OP_QUERY) begin
      query_img[pos] = pix;
    end else begin
      diff = int'(pix) - int'(query_img[pos]);
      if (diff < 0) diff = -diff;
      sum = {1'b0, dist_acc} + (DIST_W+1)'(diff * diff);
      dist_acc = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];
    end
    if (lp) pix_pos = 0;
    else pix_pos = (pos + 1 >= IMG_PIXELS) ? 0 : pos + 1;
    if (op == OP_TRAIN && lp) begin
      rank_image(dist_acc, lab);
      dist_acc = '0;
      if (li) begin
        expected_votes.push_back(tally_votes());
        clear_ranking();
      end
    end
  endfunction

  always @(posedge clk) begin : watch
    verdict_t want;
    if (!rst_n) begin
      pix_pos  = 0;
      dist_acc = '0;
      vote_k   = K_RESET;
      clear_ranking();
      expected_votes.delete();
    end else begin
      // Compare a delivered result with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_votes.size() == 0) begin
          $error("unexpected result: predicted_label %0d vote_count %0d",
                 out_predicted_label, out_vote_count);
          fail_count++;
        end else begin
          want = expected_votes.pop_front();
          if (out_predicted_label !== want.label) begin
            $error("predicted_label: expected %0d, actual %0d",
                   want.label, out_predicted_label);
            fail_count++;
          end
          if (out_vote_count !== want.votes) begin
            $error("vote_count: expected %0d, actual %0d", want.votes, out_vote_count);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) vote_k = cfg_k_neighbors;
      if (in_valid && !in_stall)
        take_pixel(opcode_t'(in_opcode), in_pixel, in_label, in_last_pixel, in_last_image);
    end
    pend_count = expected_votes.size();
  end

endmodule

// File: tb/sv/knn_digit_classifier_tb.sv
// Testbench top of the nearest-neighbor digit classifier: stimulus, pacing and verdict.
module knn_digit_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import knn_pkg::*;

  localparam int IMG_PIXELS    = PIXELS_PER_IMAGE_DEF;
  localparam int FAR_PIXELS    = 8;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_OFF      = 400;
  localparam int IDLE_LIMIT    = 5000;
  localparam int PHASE_ITEMS   = 55;
  localparam int PHASES        = 8;

  logic               clk;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic               in_opcode       = 1'b0;
  logic [PIX_W-1:0]   in_pixel        = '0;
  logic [LABEL_W-1:0] in_label        = '0;
  logic               in_last_pixel   = 1'b0;
  logic               in_last_image   = 1'b0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic [LABEL_W-1:0] out_predicted_label;
  logic [VOTE_W-1:0]  out_vote_count;
  logic               cfg_valid       = 1'b0;
  logic               cfg_ready;
  logic [K_W-1:0]     cfg_k_neighbors = '0;

  int                 vote_failures;
  int                 votes_pending;
  int                 burst_left      = 0;
  int                 items_sent      = 0;
  bit                 hold_off_armed  = 1'b0;
  bit                 hold_off_done   = 1'b0;
  logic [PIX_W-1:0]   query_copy [IMG_PIXELS];
  logic [PIX_W-1:0]   prev_image [$];

  knn_digit_classifier uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_pixel            (in_pixel),
    .in_label            (in_label),
    .in_last_pixel       (in_last_pixel),
    .in_last_image       (in_last_image),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_predicted_label (out_predicted_label),
    .out_vote_count      (out_vote_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_k_neighbors     (cfg_k_neighbors)
  );

  knn_vote_checker vote_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_pixel            (in_pixel),
    .in_label            (in_label),
    .in_last_pixel       (in_last_pixel),
    .in_last_image       (in_last_image),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_predicted_label (out_predicted_label),
    .out_vote_count      (out_vote_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_k_neighbors     (cfg_k_neighbors),
    .failures            (vote_failures),
    .pending             (votes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Grey level biased toward black and white
  function automatic logic [PIX_W-1:0] pick_level();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // Offer one item, hold it until accepted, then pace the next burst
  task automatic push_pixel(input opcode_t op, input logic [PIX_W-1:0] pix,
                            input logic [LABEL_W-1:0] lab, input bit lp, input bit li);
    int gap;
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_pixel      <= pix;
    in_label      <= lab;
    in_last_pixel <= lp;
    in_last_image <= li;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 20);
    end
  endtask

  task automatic write_k(input logic [K_W-1:0] value);
    cfg_valid       <= 1'b1;
    cfg_k_neighbors <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid, drain every expected vote, then let image ends reach the list
  task automatic settle();
    in_valid <= 1'b0;
    while (votes_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One training image with stray query items and flags mixed in
  task automatic send_image(input logic [LABEL_W-1:0] lab, input bit ends_set);
    logic [PIX_W-1:0] pixels [$];
    int               len;
    bit               lp;
    if (prev_image.size() > 0 && $urandom_range(0, 3) == 0) begin
      pixels = prev_image;
    end else begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) pixels.push_back(pick_level());
    end
    prev_image = pixels;
    for (int i = 0; i < pixels.size(); i++) begin
      if ($urandom_range(0, 15) == 0)
        push_pixel(OP_QUERY, pick_level(), LABEL_W'($urandom), 1'($urandom), 1'($urandom));
      lp = (i == pixels.size() - 1);
      push_pixel(OP_TRAIN, pixels[i], lp ? lab : LABEL_W'($urandom), lp,
                 lp ? ends_set : ($urandom_range(0, 7) == 0));
    end
  endtask

  task automatic send_set();
    int images;
    images = $urandom_range(1, 8);
    for (int i = 0; i < images; i++)
      send_image(LABEL_W'(($urandom_range(0, 7) == 0) ? $urandom_range(10, 15)
                                                      : $urandom_range(0, 9)),
                 i == images - 1);
  endtask

  // Receiver: stall on random patterns, with one long hold-off
  initial begin : receiver
    int mode;
    int span;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_armed && !hold_off_done) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_OFF) @(negedge clk);
        hold_off_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // End the run when no channel moves for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [K_W-1:0] k_plan [PHASES];
    int             phase_start;
    k_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd0, 4'd0};
    k_plan[6] = K_W'($urandom_range(0, 15));
    k_plan[7] = K_W'($urandom_range(0, 15));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill the whole query store; the index wraps back to zero on its own
    for (int i = 0; i < IMG_PIXELS; i++) begin
      query_copy[i] = pick_level();
      push_pixel(OP_QUERY, query_copy[i], LABEL_W'($urandom), 1'b0, 1'($urandom));
    end

    // A short far image, then a near image that ends the set
    for (int i = 0; i < FAR_PIXELS; i++)
      push_pixel(OP_TRAIN, (query_copy[i] >= 8'd128) ? 8'h00 : 8'hFF,
                 (i == FAR_PIXELS - 1) ? 4'd8 : LABEL_W'($urandom),
                 i == FAR_PIXELS - 1, 1'b0);
    push_pixel(OP_TRAIN, pick_level(), 4'd6, 1'b1, 1'b1);

    // Tied distances, lone last_image, query flags, out-of-range label
    push_pixel(OP_TRAIN, 8'hFF, 4'd9, 1'b0, 1'b0);
    push_pixel(OP_TRAIN, 8'hFF, 4'd9, 1'b1, 1'b0);
    push_pixel(OP_TRAIN, 8'h00, 4'd0, 1'b1, 1'b0);
    push_pixel(OP_TRAIN, 8'hFF, 4'd3, 1'b0, 1'b1);
    push_pixel(OP_TRAIN, 8'hFF, 4'd3, 1'b1, 1'b0);
    push_pixel(OP_QUERY, 8'h00, 4'd15, 1'b1, 1'b1);
    push_pixel(OP_TRAIN, 8'h80, 4'd15, 1'b1, 1'b0);
    push_pixel(OP_TRAIN, 8'h01, 4'd9, 1'b1, 1'b1);
    // Fewer entries than k
    push_pixel(OP_TRAIN, 8'h11, 4'd4, 1'b1, 1'b1);
    // No entry votes
    push_pixel(OP_TRAIN, 8'h7F, 4'd12, 1'b1, 1'b0);
    push_pixel(OP_TRAIN, 8'hAA, 4'd10, 1'b1, 1'b1);
    // Vote tie goes to the smaller label
    push_pixel(OP_TRAIN, 8'h55, 4'd2, 1'b1, 1'b0);
    push_pixel(OP_TRAIN, 8'h33, 4'd1, 1'b1, 1'b0);
    push_pixel(OP_TRAIN, 8'hCC, 4'd2, 1'b1, 1'b0);
    push_pixel(OP_TRAIN, 8'h0F, 4'd1, 1'b1, 1'b1);

    // Random phases, each under its own k; a phase may leave a set open
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_k(k_plan[ph]);
      if (ph == 1) hold_off_armed = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_set();
      repeat ($urandom_range(0, 2)) send_image(LABEL_W'($urandom_range(0, 9)), 1'b0);
    end

    settle();
    if (vote_failures == 0 && votes_pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
